// ===== design/ermt_pkg.sv =====
`default_nettype none
package ermt_pkg;

	localparam int TABLE_DEPTH = 8;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int HELD_W = 4;

	typedef enum logic [1:0] {
		FUNC_RECORD      = 2'd0,
		FUNC_TAKE_MATCH  = 2'd1,
		FUNC_TAKE_OLDEST = 2'd2,
		FUNC_CLEAR       = 2'd3
	} func_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] seq;
		logic [31:0] src;
	} entry_t;

	typedef struct packed {
		logic  go;
		func_t op;
		logic  full;
	} cell_ctl_t;

	typedef struct packed {
		logic   hit;
		entry_t data;
	} chain_t;

endpackage
`default_nettype wire

// ===== design/ermt_cell.sv =====
`default_nettype none
module ermt_cell (
	input  wire                 clk,
	input  ermt_pkg::cell_ctl_t ctl,
	input  ermt_pkg::entry_t    req,
	input  wire                 occupied,
	input  wire                 write_here,
	input  ermt_pkg::entry_t    up_entry,
	input  ermt_pkg::chain_t    chain_in,
	output ermt_pkg::chain_t    chain_out,
	output ermt_pkg::entry_t    cur
);
	import ermt_pkg::*;

	entry_t entry_q;
	logic   eq;
	logic   take_local;
	logic   sel;
	logic   shift;
	logic   is_rec;

	always_comb begin
		is_rec = (ctl.op == FUNC_RECORD);
		eq = (entry_q.id == req.id) && (entry_q.seq == req.seq);
		case (ctl.op)
			FUNC_TAKE_MATCH:  take_local = occupied && eq;
			FUNC_TAKE_OLDEST: take_local = occupied;
			default:          take_local = 1'b0;
		endcase
		sel = take_local && !chain_in.hit;
		chain_out.hit = chain_in.hit || take_local;
		chain_out.data = sel ? entry_q : chain_in.data;
		shift = is_rec ? ctl.full : (chain_in.hit || sel);
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			if (is_rec && write_here) begin
				entry_q <= req;
			end else if (shift) begin
				entry_q <= up_entry;
			end
		end
	end

	assign cur = entry_q;

endmodule
`default_nettype wire

// ===== design/echo_reply_match_table_unit.sv =====
// Echo reply match table.
// Input channel (in_valid/in_ready) carries one operation per item: func selects
// record, take matching, take oldest or clear; identifier, sequence_req and
// source_address form the request. Output channel (out_valid/out_ready) returns
// exactly one result item per input item: found, the removed entry's fields
// (zero when nothing was removed), oldest_dropped and entries_held.
// Each table slot is a cell; slot 0 is the oldest. All cells compare against
// the request in parallel, a hit chain runs from the oldest cell to pick the
// first match, and cells at or above the removal point load from their younger
// neighbor in the same cycle.
// out_valid is registered, rising in the cycle after acceptance. Throughput: one
// item per cycle while out_ready is high, set by the cell row update and one
// output register. Reset empties the table (count to zero) and clears out_valid;
// entry contents are not cleared. When the receiver stalls, the result holds in
// the output register and in_ready stays low until it is taken.
`default_nettype none
module echo_reply_match_table_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  ermt_pkg::func_t    func,
	input  wire  [15:0]        identifier,
	input  wire  [15:0]        sequence_req,
	input  wire  [31:0]        source_address,
	output logic               out_valid,
	input  wire                out_ready,
	output logic               found,
	output logic [15:0]        reply_identifier,
	output logic [15:0]        reply_sequence,
	output logic [31:0]        reply_source,
	output logic               oldest_dropped,
	output logic [3:0]         entries_held
);
	import ermt_pkg::*;

	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        cnt_nxt;
	logic [CNT_W+HELD_W-1:0] cnt_ext;
	logic                    acc;
	logic                    full;
	logic [CNT_W-1:0]        wr_idx;
	cell_ctl_t               ctl;
	entry_t                  req;
	entry_t                  ent [TABLE_DEPTH];
	chain_t                  chain [TABLE_DEPTH+1];
	logic                    out_valid_q;
	logic                    found_q;
	entry_t                  reply_q;
	logic                    dropped_q;
	logic [HELD_W-1:0]       held_q;

	assign in_ready = !out_valid_q || out_ready;
	assign acc = in_valid && in_ready;
	assign full = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign wr_idx = full ? CNT_W'(TABLE_DEPTH - 1) : cnt_q;
	assign req = '{id: identifier, seq: sequence_req, src: source_address};
	assign ctl = '{go: acc, op: func, full: full};
	assign chain[0] = '{hit: 1'b0, data: '0};

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		entry_t up;
		if (k == TABLE_DEPTH - 1) begin : g_top
			assign up = req;
		end else begin : g_mid
			assign up = ent[k+1];
		end
		ermt_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.req        (req),
			.occupied   (CNT_W'(k) < cnt_q),
			.write_here (wr_idx == CNT_W'(k)),
			.up_entry   (up),
			.chain_in   (chain[k]),
			.chain_out  (chain[k+1]),
			.cur        (ent[k])
		);
	end

	always_comb begin
		case (func)
			FUNC_RECORD:      cnt_nxt = full ? cnt_q : cnt_q + 1'b1;
			FUNC_TAKE_MATCH,
			FUNC_TAKE_OLDEST: cnt_nxt = chain[TABLE_DEPTH].hit ? cnt_q - 1'b1 : cnt_q;
			default:          cnt_nxt = '0;
		endcase
		cnt_ext = {{HELD_W{1'b0}}, cnt_nxt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			found_q <= chain[TABLE_DEPTH].hit;
			reply_q <= chain[TABLE_DEPTH].data;
			dropped_q <= (func == FUNC_RECORD) && full;
			held_q <= cnt_ext[HELD_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign reply_identifier = reply_q.id;
	assign reply_sequence = reply_q.seq;
	assign reply_source = reply_q.src;
	assign oldest_dropped = dropped_q;
	assign entries_held = held_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		acc && func == FUNC_RECORD && full |=> oldest_dropped && !found)
		else $error("record into full table did not report a drop");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc && func == FUNC_CLEAR |=> cnt_q == '0 && !found && !oldest_dropped)
		else $error("clear left entries");

	a_take_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (func == FUNC_TAKE_MATCH || func == FUNC_TAKE_OLDEST)
		|=> cnt_q == $past(cnt_q) - CNT_W'(found))
		else $error("take changed count inconsistently with found");

endmodule
`default_nettype wire

// ===== bench/tb_echo_reply_match_table_unit.sv =====
`default_nettype none
module tb_echo_reply_match_table_unit;
	import ermt_pkg::*;

	localparam int ITEM_TOTAL = 750;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic        found;
		logic [15:0] id;
		logic [15:0] seq;
		logic [31:0] src;
		logic        dropped;
		logic [3:0]  held;
	} reply_t;

	class echo_reply_ledger;
		entry_t slots[$];
		reply_t pending_replies[$];
		int     fails;

		function void note_item(func_t op, logic [15:0] id, logic [15:0] seq,
				logic [31:0] src);
			reply_t r;
			entry_t e;
			int     pos;
			r = '0;
			pos = -1;
			case (op)
			FUNC_RECORD: begin
				if (slots.size() >= TABLE_DEPTH) begin
					void'(slots.pop_front());
					r.dropped = 1'b1;
				end
				e.id = id;
				e.seq = seq;
				e.src = src;
				slots.push_back(e);
			end
			FUNC_TAKE_MATCH: begin
				foreach (slots[k])
					if (pos < 0 && slots[k].id == id && slots[k].seq == seq)
						pos = k;
			end
			FUNC_TAKE_OLDEST: begin
				if (slots.size() > 0)
					pos = 0;
			end
			default: begin
				slots.delete();
			end
			endcase
			if (pos >= 0) begin
				r.found = 1'b1;
				r.id = slots[pos].id;
				r.seq = slots[pos].seq;
				r.src = slots[pos].src;
				slots.delete(pos);
			end
			r.held = 4'(slots.size());
			pending_replies.push_back(r);
		endfunction

		function void log_mismatch(string name, logic [31:0] want, logic [31:0] got);
			fails++;
			if (fails <= 10)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (pending_replies.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("result with nothing pending: %p", got);
				return;
			end
			want = pending_replies.pop_front();
			if (got.found !== want.found)
				log_mismatch("found", want.found, got.found);
			if (got.id !== want.id)
				log_mismatch("reply_identifier", want.id, got.id);
			if (got.seq !== want.seq)
				log_mismatch("reply_sequence", want.seq, got.seq);
			if (got.src !== want.src)
				log_mismatch("reply_source", want.src, got.src);
			if (got.dropped !== want.dropped)
				log_mismatch("oldest_dropped", want.dropped, got.dropped);
			if (got.held !== want.held)
				log_mismatch("entries_held", want.held, got.held);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	func_t       func_d;
	logic [15:0] id_d;
	logic [15:0] seq_d;
	logic [31:0] src_d;
	logic        out_valid;
	logic        out_ready;
	logic        found;
	logic [15:0] reply_identifier;
	logic [15:0] reply_sequence;
	logic [31:0] reply_source;
	logic        oldest_dropped;
	logic [3:0]  entries_held;

	echo_reply_ledger ledger = new();
	int unsigned      cycles = 0;
	bit               in_steady = 1'b0;

	echo_reply_match_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func_d),
		.identifier(id_d),
		.sequence_req(seq_d),
		.source_address(src_d),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.reply_identifier(reply_identifier),
		.reply_sequence(reply_sequence),
		.reply_source(reply_source),
		.oldest_dropped(oldest_dropped),
		.entries_held(entries_held)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_reply({found, reply_identifier, reply_sequence, reply_source,
				oldest_dropped, entries_held});
	end

	task automatic send_item(func_t op, logic [15:0] id, logic [15:0] seq,
			logic [31:0] src);
		int gap;
		gap = in_steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func_d <= op;
		id_d <= id;
		seq_d <= seq;
		src_d <= src;
		do @(posedge clk); while (!in_ready);
		ledger.note_item(op, id, seq, src);
	endtask

	task automatic send_random();
		func_t       op;
		logic [15:0] id;
		logic [15:0] seq;
		logic [31:0] src;
		int          roll;
		int          pick;
		int          n;
		roll = $urandom_range(0, 99);
		id = 16'($urandom);
		seq = 16'($urandom);
		src = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			id = 16'($urandom_range(0, 3));
			seq = 16'($urandom_range(0, 3));
		end
		n = ledger.slots.size();
		if (roll < 45) begin
			op = FUNC_RECORD;
			if (n > 0 && $urandom_range(0, 3) == 0) begin
				pick = $urandom_range(0, n - 1);
				id = ledger.slots[pick].id;
				seq = ledger.slots[pick].seq;
			end
		end else if (roll < 75) begin
			op = FUNC_TAKE_MATCH;
			if (n > 0 && $urandom_range(0, 4) != 0) begin
				pick = $urandom_range(0, n - 1);
				id = ledger.slots[pick].id;
				seq = ledger.slots[pick].seq;
				if ($urandom_range(0, 5) == 0)
					seq = seq ^ (16'h1 << $urandom_range(0, 15));
			end
		end else if (roll < 95) begin
			op = FUNC_TAKE_OLDEST;
		end else begin
			op = FUNC_CLEAR;
		end
		send_item(op, id, seq, src);
	endtask

	initial begin
		int gap;
		int taken;
		bit steady;
		taken = 0;
		steady = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			gap = steady ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		func_d = FUNC_RECORD;
		id_d = '0;
		seq_d = '0;
		src_d = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(FUNC_TAKE_OLDEST, 16'h0000, 16'h0000, 32'h0000_0000);
		send_item(FUNC_TAKE_MATCH, 16'hffff, 16'hffff, 32'hffff_ffff);
		send_item(FUNC_CLEAR, 16'h0000, 16'h0000, 32'h0000_0000);
		send_item(FUNC_RECORD, 16'h0000, 16'h0000, 32'h0000_0000);
		send_item(FUNC_RECORD, 16'hffff, 16'hffff, 32'hffff_ffff);
		send_item(FUNC_RECORD, 16'h1234, 16'h0001, 32'hc0a8_0001);
		send_item(FUNC_RECORD, 16'h1234, 16'h0001, 32'h0a00_0001);
		send_item(FUNC_TAKE_MATCH, 16'hffff, 16'hffff, 32'h0000_0000);
		repeat (5)
			send_item(FUNC_RECORD, 16'($urandom), 16'($urandom), $urandom);
		send_item(FUNC_RECORD, 16'h5555, 16'haaaa, 32'h5555_aaaa);
		send_item(FUNC_TAKE_MATCH, 16'h1234, 16'h0001, 32'h0000_0000);
		send_item(FUNC_TAKE_MATCH, 16'h1234, 16'h0001, 32'h0000_0000);
		send_item(FUNC_TAKE_MATCH, 16'h1234, 16'h0002, 32'h0000_0000);
		send_item(FUNC_TAKE_MATCH, 16'h5554, 16'haaaa, 32'h0000_0000);
		send_item(FUNC_TAKE_MATCH, 16'h5555, 16'haaaa, 32'h0000_0000);
		send_item(FUNC_TAKE_OLDEST, 16'h0000, 16'h0000, 32'h0000_0000);
		send_item(FUNC_CLEAR, 16'hffff, 16'hffff, 32'hffff_ffff);
		send_item(FUNC_TAKE_MATCH, 16'h0000, 16'h0000, 32'h0000_0000);
		send_item(FUNC_TAKE_OLDEST, 16'h0000, 16'h0000, 32'h0000_0000);

		for (int i = 0; i < ITEM_TOTAL; i++) begin
			if (i % 40 == 0)
				in_steady = ($urandom_range(0, 3) == 0);
			send_random();
		end
		in_valid <= 1'b0;

		while (ledger.pending_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (ledger.fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
